>>> rtl/rc_serial_frame_decoder_unit_assert.svh
// assertion macros shared by the decoder checker
`ifndef RC_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH
`define RC_SERIAL_FRAME_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on aclk, quiet during reset
`define RCFD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on aclk, quiet during reset
`define RCFD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rcfd_pkg.sv
// shared constants and interface types of the serial frame decoder
`default_nettype none

package rcfd_pkg;

    localparam int RING_LEN  = 25;
    localparam int NUM_CH    = 16;
    localparam int CH_W      = 11;
    localparam int FRM_BYTES = 22;
    localparam int FRM_W     = FRM_BYTES * 8;
    localparam int NUM_W     = 16;
    localparam int PROD_W    = 31;
    localparam int QUOT_W    = 7;

    localparam logic [7:0]      SYNC_HEAD = 8'h0f;
    localparam logic [7:0]      SYNC_TAIL = 8'h00;
    localparam logic [CH_W-1:0] RAW_LOW   = 11'd340;
    localparam logic [6:0]      PCT_SCALE = 7'd100;
    localparam logic [10:0]     PCT_DIV   = 11'd1364;
    localparam logic [3:0]      LAST_CH   = 4'd15;

    // 100/1364 reduces to 25/341; 2^24/341 rounded up is exact for every magnitude
    localparam logic [4:0]      PCT_NUM   = 5'd25;
    localparam logic [15:0]     PCT_RECIP = 16'd49201;

    // request to the percent scaler
    typedef struct packed {
        logic            start;
        logic [CH_W-1:0] raw;
    } div_ctrl_t;

    // answer of the percent scaler
    typedef struct packed {
        logic              done;
        logic signed [7:0] pct;
    } div_stat_t;

endpackage

`default_nettype wire

>>> rtl/rcfd_frame.sv
// byte shift line with sync detection and channel bit snapshot
`default_nettype none

module rcfd_frame (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      push,
    input  wire logic [7:0]                byte_in,
    input  wire logic                      advance,
    output logic                           sync,
    output logic [rcfd_pkg::CH_W-1:0]      raw
);

    logic [7:0]                 ring_reg  [rcfd_pkg::RING_LEN];
    logic [7:0]                 ring_next [rcfd_pkg::RING_LEN];
    logic [rcfd_pkg::FRM_W-1:0] frm_reg;
    logic [rcfd_pkg::FRM_W-1:0] frm_next;

    // tap 0 is the oldest byte, the top tap the newest
    assign sync = (byte_in == rcfd_pkg::SYNC_TAIL) && (ring_reg[1] == rcfd_pkg::SYNC_HEAD);
    assign raw  = frm_reg[rcfd_pkg::CH_W-1:0];

    always_comb begin
        for (int i = 0; i < rcfd_pkg::RING_LEN; i++) begin
            ring_next[i] = ring_reg[i];
        end
        if (push) begin
            for (int i = 0; i < rcfd_pkg::RING_LEN - 1; i++) begin
                ring_next[i] = ring_reg[i+1];
            end
            ring_next[rcfd_pkg::RING_LEN-1] = byte_in;
        end
    end

    // frame bytes 1 to 22 after the shift sit in taps 2 to 23 before it
    always_comb begin
        frm_next = frm_reg;
        if (push && sync) begin
            for (int j = 0; j < rcfd_pkg::FRM_BYTES; j++) begin
                frm_next[8*j +: 8] = ring_reg[j+2];
            end
        end else if (advance) begin
            frm_next = frm_reg >> rcfd_pkg::CH_W;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < rcfd_pkg::RING_LEN; i++) begin
                ring_reg[i] <= 8'h00;
            end
        end else begin
            for (int i = 0; i < rcfd_pkg::RING_LEN; i++) begin
                ring_reg[i] <= ring_next[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        frm_reg <= frm_next;
    end

endmodule

`default_nettype wire

>>> rtl/rcfd_pct_div.sv
// percent scaler by reciprocal multiplication, two register stages
`default_nettype none

module rcfd_pct_div (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire rcfd_pkg::div_ctrl_t ctrl,
    output rcfd_pkg::div_stat_t      stat
);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic                        neg_reg,  neg_next;
    logic [rcfd_pkg::NUM_W-1:0]  num_reg,  num_next;
    logic [rcfd_pkg::QUOT_W-1:0] quot_reg, quot_next;
    logic [rcfd_pkg::CH_W-1:0]   mag;
    logic [rcfd_pkg::PROD_W-1:0] prod;

    // magnitude of raw minus the low end
    assign mag  = (ctrl.raw >= rcfd_pkg::RAW_LOW) ? (ctrl.raw - rcfd_pkg::RAW_LOW)
                                                  : (rcfd_pkg::RAW_LOW - ctrl.raw);
    // quotient by 341 sits in the top bits of the product
    assign prod = rcfd_pkg::PROD_W'(num_reg) * rcfd_pkg::PROD_W'(rcfd_pkg::PCT_RECIP);

    always_comb begin
        busy_next = 1'b0;
        done_next = 1'b0;
        neg_next  = neg_reg;
        num_next  = num_reg;
        quot_next = quot_reg;
        if (ctrl.start) begin
            busy_next = 1'b1;
            neg_next  = (ctrl.raw < rcfd_pkg::RAW_LOW);
            num_next  = rcfd_pkg::NUM_W'(mag) * rcfd_pkg::NUM_W'(rcfd_pkg::PCT_NUM);
        end else if (busy_reg) begin
            done_next = 1'b1;
            quot_next = prod[rcfd_pkg::PROD_W-1 -: rcfd_pkg::QUOT_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg  <= neg_next;
        num_reg  <= num_next;
        quot_reg <= quot_next;
    end

    // magnitude quotient, so the sign fix truncates toward zero
    assign stat.done = done_reg;
    assign stat.pct  = neg_reg ? (8'sd0 - $signed({1'b0, quot_reg}))
                               : $signed({1'b0, quot_reg});

endmodule

`default_nettype wire

>>> rtl/rc_serial_frame_decoder_unit.sv
// top level of the 16-channel serial frame decoder
//
//  port group  dir  payload (low bit first)                              handshake
//  s_*         in   tdata[7:0] byte_in                                   tvalid/tready
//  m_*         out  tdata channel[3:0] raw_value[14:4] percent[22:15]    tvalid/tready
//                   pad[23], tlast last_channel
//
// a byte that does not complete a sync pattern leaves s_tready high
// a sync byte starts a decode of 16 channels; when the sink keeps up each channel steps through
// one scaler start, one reciprocal product, one done beat and one emit,
// so s_tready stays low from the sync beat until the last emit; m_tready low stretches each emit
// the shared percent scaler loop paces the decode; the output register holds a beat
// while the next channel is scaled
// aresetn is synchronous, active low, and clears the byte line to zero
`default_nettype none

module rc_serial_frame_decoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // byte_in[7:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // channel[3:0], raw_value[14:4], percent[22:15], pad
    output logic             m_tlast    // last_channel
);

    // one-hot sequencer states
    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_START = 4'b0010,
        ST_CALC  = 4'b0100,
        ST_EMIT  = 4'b1000
    } st_t;

    st_t                          st_reg, st_next;
    logic [3:0]                   chan_reg, chan_next;
    logic                         m_valid_reg, m_valid_next;
    logic [23:0]                  m_data_reg, m_data_next;
    logic                         m_last_reg, m_last_next;
    logic                         s_acc;
    logic                         sync;
    logic                         out_free;
    logic                         emit;
    logic [rcfd_pkg::CH_W-1:0]    raw;
    rcfd_pkg::div_ctrl_t          div_ctrl;
    rcfd_pkg::div_stat_t          div_stat;

    assign s_tready = (st_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign emit     = (st_reg == ST_EMIT) && out_free;

    // byte line, sync test and the unpacked channel bits
    rcfd_frame u_frame (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_acc),
        .byte_in (s_tdata),
        .advance (emit),
        .sync    (sync),
        .raw     (raw)
    );

    // shared scaler, started once per channel
    assign div_ctrl.start = (st_reg == ST_START);
    assign div_ctrl.raw   = raw;

    rcfd_pct_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (div_ctrl),
        .stat    (div_stat)
    );

    always_comb begin
        st_next      = st_reg;
        chan_next    = chan_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;

        // the sink took the waiting beat
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        case (st_reg)
            ST_IDLE: begin
                if (s_acc && sync) begin
                    chan_next = 4'd0;
                    st_next   = ST_START;
                end
            end
            ST_START: begin
                st_next = ST_CALC;
            end
            ST_CALC: begin
                if (div_stat.done) begin
                    st_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, div_stat.pct, raw, chan_reg};
                    m_last_next  = (chan_reg == rcfd_pkg::LAST_CH);
                    chan_next    = chan_reg + 4'd1;
                    st_next      = (chan_reg == rcfd_pkg::LAST_CH) ? ST_IDLE : ST_START;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg      <= ST_IDLE;
            chan_reg    <= 4'd0;
            m_valid_reg <= 1'b0;
        end else begin
            st_reg      <= st_next;
            chan_reg    <= chan_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // output payload needs no reset
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

endmodule

`default_nettype wire

>>> rtl/rcfd_checker.sv
// port-level checks of the frame decoder, bound to the top level
`default_nettype none

`include "rc_serial_frame_decoder_unit_assert.svh"

module rcfd_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [7:0]  s_tdata,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata,
    input  wire logic        m_tlast
);

    // a stalled beat holds
`RCFD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result beat changed")

    // percent stays inside its span
`RCFD_ASSERT_NOW(a_pct_span, m_tvalid, ($signed(m_tdata[22:15]) >= -8'sd24) && ($signed(m_tdata[22:15]) <= 8'sd125), "percent outside span")

    // below the low end the percent is never positive
`RCFD_ASSERT_NOW(a_pct_sign, m_tvalid && (m_tdata[14:4] < 11'd340), m_tdata[22] || (m_tdata[22:15] == 8'd0), "percent sign wrong")

    // last flag only on the top channel
`RCFD_ASSERT_NOW(a_last_chan, m_tvalid && m_tlast, m_tdata[3:0] == 4'd15, "last flag on wrong channel")

    // no byte is taken while a frame is still being emitted
`RCFD_ASSERT_NOW(a_busy_mid, m_tvalid && !m_tlast, !s_tready, "input ready in mid frame")

endmodule

bind rc_serial_frame_decoder_unit rcfd_checker u_rcfd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> tb/sv/tb_rc_serial_frame_decoder_unit.sv
// self-checking testbench and channel scoreboard for the serial frame decoder
`timescale 1ns / 100ps

// one decoded channel as it should leave the block
typedef struct packed {
    logic                      last;
    logic signed [7:0]         pct;
    logic [rcfd_pkg::CH_W-1:0] raw;
    logic [3:0]                ch;
} chan_beat_t;

// mirrors the byte ring and queues the sixteen channels of every sync
class channel_scoreboard;
    logic [7:0]  ring [rcfd_pkg::RING_LEN];
    int unsigned wpos;
    chan_beat_t  expected_channels [$];
    int          mismatches;
    int          beats_checked;
    int          frames_found;
    int          bytes_noted;

    function new();
        foreach (ring[i]) ring[i] = 8'h00;
        wpos          = 0;
        mismatches    = 0;
        beats_checked = 0;
        frames_found  = 0;
        bytes_noted   = 0;
    endfunction

    // write the accepted byte and, on a sync, unpack the whole frame
    function void note_byte(logic [7:0] b);
        int unsigned                nxt;
        int                         i;
        int                         k;
        int                         pct_full;
        logic [rcfd_pkg::FRM_W-1:0] bits;
        chan_beat_t                 beat;
        ring[wpos] = b;
        nxt = (wpos == rcfd_pkg::RING_LEN - 1) ? 0 : wpos + 1;
        bytes_noted++;
        // the slot about to be overwritten holds the oldest byte
        if (b == rcfd_pkg::SYNC_TAIL && ring[nxt] == rcfd_pkg::SYNC_HEAD) begin
            // channel stream starts at frame byte 1, lsb first
            for (i = 0; i < rcfd_pkg::FRM_BYTES; i++)
                bits[i*8 +: 8] = ring[(nxt + 1 + i) % rcfd_pkg::RING_LEN];
            for (k = 0; k < rcfd_pkg::NUM_CH; k++) begin
                beat.ch  = 4'(k);
                beat.raw = bits[k*rcfd_pkg::CH_W +: rcfd_pkg::CH_W];
                // integer division truncates toward zero
                pct_full  = (int'(beat.raw) - int'(rcfd_pkg::RAW_LOW))
                            * int'(rcfd_pkg::PCT_SCALE) / int'(rcfd_pkg::PCT_DIV);
                beat.pct  = 8'(pct_full);
                beat.last = (k == rcfd_pkg::NUM_CH - 1);
                expected_channels.push_back(beat);
            end
            frames_found++;
        end
        wpos = nxt;
    endfunction

    function void check_channel(logic [23:0] data, logic last_flag);
        chan_beat_t want;
        beats_checked++;
        if (expected_channels.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected beat: ch=%0d raw=%0d pct=%0d last=%0b",
                         data[3:0], data[14:4], $signed(data[22:15]), last_flag);
            return;
        end
        want = expected_channels.pop_front();
        if (data[3:0] !== want.ch || data[14:4] !== want.raw || data[22:15] !== want.pct
                || data[23] !== 1'b0 || last_flag !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $write("beat %0d mismatch: want ch=%0d raw=%0d pct=%0d last=%0b pad=0, ",
                       beats_checked, want.ch, want.raw, want.pct, want.last);
                $display("got ch=%0d raw=%0d pct=%0d last=%0b pad=%0b",
                         data[3:0], data[14:4], $signed(data[22:15]), last_flag, data[23]);
            end
        end
    endfunction
endclass

module tb_rc_serial_frame_decoder_unit;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int HOLD_CYCLES  = 400;   // long sink hold-off, well past one decode
    localparam int TARGET_BYTES = 180;
    localparam int DRAIN_CYCLES = 200;   // longer than one decode

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'h00;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;
    logic        m_tlast;

    channel_scoreboard sb = new();
    int cycle_count = 0;
    bit held_once   = 1'b0;

    always #1 aclk = ~aclk;

    rc_serial_frame_decoder_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // watchdog: a hung handshake ends the run here
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // idle length: mostly none, sometimes a few cycles, now and then a long gap
    function automatic int gap_len(bit quiet);
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    // channel value biased towards the edges of the percent scale
    function automatic logic [rcfd_pkg::CH_W-1:0] pick_raw();
        case ($urandom_range(0, 9))
            0: return 11'd0;
            1: return 11'd2047;
            2: return 11'd339;   // just below centre-low, truncates to zero
            3: return 11'd340;
            4: return 11'd341;
            5: return 11'd1703;
            6: return 11'd1704;
            7: return 11'd1705;
            default: return 11'($urandom_range(0, 2047));
        endcase
    endfunction

    // offer one byte and hold it until the block takes the beat
    task automatic send_byte(input logic [7:0] b, input bit quiet);
        int gap;
        gap = gap_len(quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge aclk); while (!s_tready);
        sb.note_byte(b);
    endtask

    // full frame: head, 22 packed channel bytes, flags, tail; broken ones spoil head or tail
    task automatic send_frame(input bit broken, input bit quiet);
        logic [7:0]                 fr [rcfd_pkg::RING_LEN];
        logic [rcfd_pkg::FRM_W-1:0] bits;
        int                         i;
        int                         k;
        for (k = 0; k < rcfd_pkg::NUM_CH; k++)
            bits[k*rcfd_pkg::CH_W +: rcfd_pkg::CH_W] = pick_raw();
        fr[0] = rcfd_pkg::SYNC_HEAD;
        for (i = 0; i < rcfd_pkg::FRM_BYTES; i++)
            fr[i+1] = bits[i*8 +: 8];
        fr[rcfd_pkg::RING_LEN-2] = 8'($urandom_range(0, 255));
        fr[rcfd_pkg::RING_LEN-1] = rcfd_pkg::SYNC_TAIL;
        if (broken) begin
            if ($urandom_range(0, 1) == 1)
                fr[rcfd_pkg::RING_LEN-1] = 8'($urandom_range(1, 255));
            else
                fr[0] = 8'($urandom_range(16, 255));
        end
        for (i = 0; i < rcfd_pkg::RING_LEN; i++)
            send_byte(fr[i], quiet);
    endtask

    // byte source: directed frame, then mostly well-formed frames with noise in between
    initial begin : byte_source
        int i;
        int kind;
        bit quiet;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: channels 0-7 all zero, channels 8-15 all ones, flags all ones
        send_byte(rcfd_pkg::SYNC_HEAD, 1'b0);
        for (i = 1; i < rcfd_pkg::RING_LEN - 1; i++)
            send_byte((i <= 11) ? 8'h00 : 8'hff, 1'b0);
        send_byte(rcfd_pkg::SYNC_TAIL, 1'b0);

        while (sb.bytes_noted < TARGET_BYTES) begin
            quiet = ($urandom_range(0, 3) == 0);
            kind  = $urandom_range(0, 99);
            if (kind < 70)
                send_frame(1'b0, quiet);
            else if (kind < 85)
                send_frame(1'b1, quiet);
            else
                repeat ($urandom_range(1, 6)) send_byte(8'($urandom), quiet);
        end
        s_tvalid <= 1'b0;

        // drain, then give a stray late beat the chance to show up
        while (sb.expected_channels.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d bytes, %0d sync frames, %0d channel beats checked",
                 sb.bytes_noted, sb.frames_found, sb.beats_checked);
        $display("mismatches: %0d, beats still owed: %0d",
                 sb.mismatches, sb.expected_channels.size());
        if (sb.mismatches == 0 && sb.expected_channels.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result sink with random back-pressure and one long hold-off
    initial begin : channel_sink
        int stall;
        bit quiet;
        quiet = 1'b0;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            if (!held_once && sb.beats_checked >= 20) begin
                // output stage fills up and the byte input stalls behind it
                held_once = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            if ($urandom_range(0, 15) == 0)
                quiet = ~quiet;
            stall = gap_len(quiet);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            sb.check_channel(m_tdata, m_tlast);
        end
    end

endmodule
